[rtl/timer_divider_solver_assert.svh]
// Assertion macros used by the timer divider solver checker.
`ifndef TIMER_DIVIDER_SOLVER_ASSERT_SVH
`define TIMER_DIVIDER_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tds_pkg.sv]
// Shared types and constants for the timer divider solver.
`default_nettype none

package tds_pkg;

  localparam int TGT_W          = 29;
  localparam int IN_TDATA_W     = 32;
  localparam int PRESC_W        = 16;
  localparam int PERIOD_W       = 16;
  localparam int CMP_W          = 15;
  localparam int STATUS_W       = 2;
  localparam int OUT_TDATA_W    = 48;
  localparam int PERIOD_LIMIT_DEF = 65535;

  localparam logic [TGT_W-1:0]   CLK_RESET  = TGT_W'(168000000);
  localparam logic [PRESC_W-1:0] PRESC_MAX  = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ZERO  = 2'd1,
    STATUS_ABOVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/tds_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tds_div #(
  parameter int N_W = 29,
  parameter int D_W = 45
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic      [N_W-1:0] quotient,
  output logic                done
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     trial;
  logic             fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[N_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(N_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? D_W'(trial - {1'b0, dvs_r}) : D_W'(trial);
      quo_nxt = {quo_r[N_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

[rtl/timer_divider_solver.sv]
// One request at a time: the next is accepted when the result enters the output register.
// A valid target costs three serial divisions of 29 quotient bits each on one shared bit-serial divider; an error none.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, rst_n low) empties the pipeline and sets the timer clock to 168 MHz.
`default_nettype none

module timer_divider_solver #(
  parameter int PERIOD_LIMIT = tds_pkg::PERIOD_LIMIT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [28:0] target_hz, upper bits zero
  input  wire logic [tds_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] prescale_value, [31:16] period_value, [46:32] compare_value, [47] zero
  output logic      [tds_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic      [tds_pkg::STATUS_W-1:0]       out_tuser,
  input  wire logic                               cfg_wen,
  input  wire logic [tds_pkg::TGT_W-1:0]          cfg_wdata
);

  localparam int TGT_W = tds_pkg::TGT_W;
  localparam int LIM_W = $clog2(PERIOD_LIMIT + 1);
  localparam int DVS_W = TGT_W + LIM_W;
  localparam logic [LIM_W-1:0] LIM_C   = LIM_W'(PERIOD_LIMIT);
  localparam logic [TGT_W-1:0] LIM_M1  = TGT_W'(PERIOD_LIMIT - 1);

  tds_pkg::state_t                   state_r, state_nxt;
  tds_pkg::status_t                  status_r, status_nxt;
  logic [TGT_W-1:0]                  clk_hz_r, clk_hz_nxt;
  logic [TGT_W-1:0]                  tgt_r, tgt_nxt;
  logic [tds_pkg::PRESC_W-1:0]       presc_r, presc_nxt;
  logic [tds_pkg::PERIOD_W-1:0]      period_r, period_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [tds_pkg::OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [tds_pkg::STATUS_W-1:0]      out_tuser_r, out_tuser_nxt;

  logic                              div_start;
  logic [TGT_W-1:0]                  div_dvd;
  logic [DVS_W-1:0]                  div_dvs;
  logic [TGT_W-1:0]                  div_quo;
  logic                              div_done;

  logic [TGT_W-1:0]                  in_tgt;
  logic [tds_pkg::PRESC_W-1:0]       presc_sat;
  logic [TGT_W-1:0]                  quo_m1;
  logic [tds_pkg::PERIOD_W-1:0]      period_sat;
  logic                              out_load;

  tds_div #(
    .N_W (TGT_W),
    .D_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign in_tgt    = in_tdata[TGT_W-1:0];
  assign presc_sat = (div_quo[TGT_W-1:tds_pkg::PRESC_W] != '0) ? tds_pkg::PRESC_MAX
                                                               : div_quo[tds_pkg::PRESC_W-1:0];
  assign quo_m1    = div_quo - TGT_W'(1);
  always_comb begin
    if (div_quo == '0) begin
      period_sat = '0;
    end else if (quo_m1 > LIM_M1) begin
      period_sat = tds_pkg::PERIOD_W'(LIM_M1);
    end else begin
      period_sat = tds_pkg::PERIOD_W'(quo_m1);
    end
  end

  assign out_load = (state_r == tds_pkg::ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    clk_hz_nxt     = cfg_wen ? cfg_wdata : clk_hz_r;
    tgt_nxt        = tgt_r;
    presc_nxt      = presc_r;
    period_nxt     = period_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    div_start      = 1'b0;
    div_dvd        = clk_hz_r;
    div_dvs        = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      tds_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          tgt_nxt = in_tgt;
          if (in_tgt == '0) begin
            status_nxt = tds_pkg::STATUS_ZERO;
            state_nxt  = tds_pkg::ST_DONE;
          end else if (in_tgt > clk_hz_r) begin
            status_nxt = tds_pkg::STATUS_ABOVE;
            state_nxt  = tds_pkg::ST_DONE;
          end else begin
            status_nxt = tds_pkg::STATUS_OK;
            state_nxt  = tds_pkg::ST_MUL;
          end
        end
      end
      tds_pkg::ST_MUL: begin
        // Prescaler: clock over limit times target.
        div_start = 1'b1;
        div_dvs   = DVS_W'(LIM_C) * DVS_W'(tgt_r);
        state_nxt = tds_pkg::ST_DIV1;
      end
      tds_pkg::ST_DIV1: begin
        if (div_done) begin
          presc_nxt = presc_sat;
          div_start = 1'b1;
          div_dvs   = DVS_W'({1'b0, presc_sat} + 17'd1);
          state_nxt = tds_pkg::ST_DIV2;
        end
      end
      tds_pkg::ST_DIV2: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = div_quo;
          div_dvs   = DVS_W'(tgt_r);
          state_nxt = tds_pkg::ST_DIV3;
        end
      end
      tds_pkg::ST_DIV3: begin
        if (div_done) begin
          period_nxt = period_sat;
          state_nxt  = tds_pkg::ST_DONE;
        end
      end
      tds_pkg::ST_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = status_r;
          if (status_r == tds_pkg::STATUS_OK) begin
            out_tdata_nxt = {1'b0, period_r[tds_pkg::PERIOD_W-1:1], period_r, presc_r};
          end else begin
            out_tdata_nxt = '0;
          end
          state_nxt = tds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tgt_r       <= tgt_nxt;
    presc_r     <= presc_nxt;
    period_r    <= period_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (!rst_n) begin
      state_r      <= tds_pkg::ST_IDLE;
      clk_hz_r     <= tds_pkg::CLK_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clk_hz_r     <= clk_hz_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == tds_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

[rtl/tds_checker.sv]
// Port-level checks for the timer divider solver, bound to the top level.
`default_nettype none
`include "timer_divider_solver_assert.svh"

module tds_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [tds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [tds_pkg::STATUS_W-1:0]     out_tuser
);

  // A stalled result must hold its valid and its payload.
  `TDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only one request is in flight, so ready drops right after an accept.
  `TDS_ASSERT_NEXT(a_one_request, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken while busy")

  // Error results carry all-zero values.
  `TDS_ASSERT_SAME(a_err_zero, clk, rst_n, out_tvalid && (out_tuser != tds_pkg::STATUS_OK), out_tdata == '0, "error result with nonzero values")

  // The compare value is always the period halved.
  `TDS_ASSERT_SAME(a_cmp_half, clk, rst_n, out_tvalid, out_tdata[46:32] == out_tdata[31:17], "compare is not half the period")

endmodule

bind timer_divider_solver tds_checker u_tds_checker (.*);

`default_nettype wire
